>>> sv/vpsc_pkg.sv
// Shared types, codes and reset constants of the vehicle power-state controller.
// No dependencies; used by every module of the block.
package vpsc_pkg;

    // Register indexes on the configuration channel
    localparam int unsigned CfgIdxW  = 3;
    localparam int unsigned CfgDataW = 20;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_LEADER_MODE   = 3'd0,
        CFG_BOOT_TIME     = 3'd1,
        CFG_FOLLOWER_TMO  = 3'd2,
        CFG_SLEEP_HOLD    = 3'd3,
        CFG_BRAKE_THRESH  = 3'd4,
        CFG_TICK_MS       = 3'd5
    } cfg_idx_t;

    // Reset values of the configuration registers
    localparam logic        RstLeaderMode  = 1'b1;
    localparam logic [15:0] RstBootTimeMs  = 16'd250;
    localparam logic [15:0] RstFollowerTmo = 16'd1000;
    localparam logic [19:0] RstSleepHoldMs = 20'd60000;
    localparam logic [9:0]  RstBrakeThresh = 10'd100;  // 10.0 percent
    localparam logic [7:0]  RstTickMs      = 8'd10;

    // Vehicle state codes as seen on the result channel
    localparam logic [2:0] CODE_INIT   = 3'd0;
    localparam logic [2:0] CODE_ON_GLV = 3'd1;
    localparam logic [2:0] CODE_ON_HV  = 3'd2;
    localparam logic [2:0] CODE_TS_RUN = 3'd3;
    localparam logic [2:0] CODE_SLEEP  = 3'd4;

    // Opcodes of an input beat
    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_DELAY = 1'b1;

    // Internal one-hot power state
    typedef enum logic [4:0] {
        S_INIT   = 5'b00001,
        S_ON_GLV = 5'b00010,
        S_ON_HV  = 5'b00100,
        S_TS_RUN = 5'b01000,
        S_SLEEP  = 5'b10000
    } vstate_t;

    typedef struct packed {
        logic        leader_mode;
        logic [15:0] boot_delay_ms;
        logic [15:0] follower_timeout_ms;
        logic [19:0] sleep_hold_ms;
        logic [9:0]  brake_threshold;
        logic [7:0]  tick_ms;
    } cfg_t;

    typedef struct packed {
        logic        opcode;
        logic [19:0] delay_ms;
        logic        tsms_active;
        logic        run_button;
        logic        contactors_closed;
        logic        brake_valid;
        logic [9:0]  brake_tenths;
        logic        followers_sleep_ok;
        logic        uds_active;
        logic        remote_valid;
        logic [2:0]  remote_state;
    } item_t;

    typedef struct packed {
        logic [2:0] current_state;
        logic       sleepable;
    } result_t;

    function automatic logic [2:0] state_to_code(input vstate_t st);
        logic [2:0] code;
        unique case (st)
            S_INIT:   code = CODE_INIT;
            S_ON_GLV: code = CODE_ON_GLV;
            S_ON_HV:  code = CODE_ON_HV;
            S_TS_RUN: code = CODE_TS_RUN;
            S_SLEEP:  code = CODE_SLEEP;
            default:  code = CODE_INIT;
        endcase
        return code;
    endfunction

    // Codes above sleep have no state; caller filters them
    function automatic vstate_t code_to_state(input logic [2:0] code);
        vstate_t st;
        unique case (code)
            CODE_INIT:   st = S_INIT;
            CODE_ON_GLV: st = S_ON_GLV;
            CODE_ON_HV:  st = S_ON_HV;
            CODE_TS_RUN: st = S_TS_RUN;
            CODE_SLEEP:  st = S_SLEEP;
            default:     st = S_INIT;
        endcase
        return st;
    endfunction

endpackage

>>> sv/vpsc_cfg.sv
// Configuration register file of the power-state controller.
// Depends on vpsc_pkg for the register indexes, reset values and cfg_t.
module vpsc_cfg
    import vpsc_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                wr_en,
    input  logic [CfgIdxW-1:0]  wr_index,
    input  logic [CfgDataW-1:0] wr_data,
    output cfg_t                cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Decode the written index; unknown indexes are dropped
    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (wr_index)
                CFG_LEADER_MODE:  cfg_next.leader_mode         = wr_data[0];
                CFG_BOOT_TIME:    cfg_next.boot_delay_ms       = wr_data[15:0];
                CFG_FOLLOWER_TMO: cfg_next.follower_timeout_ms = wr_data[15:0];
                CFG_SLEEP_HOLD:   cfg_next.sleep_hold_ms       = wr_data[19:0];
                CFG_BRAKE_THRESH: cfg_next.brake_threshold     = wr_data[9:0];
                CFG_TICK_MS:      cfg_next.tick_ms             = wr_data[7:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.leader_mode         <= RstLeaderMode;
            cfg_reg.boot_delay_ms       <= RstBootTimeMs;
            cfg_reg.follower_timeout_ms <= RstFollowerTmo;
            cfg_reg.sleep_hold_ms       <= RstSleepHoldMs;
            cfg_reg.brake_threshold     <= RstBrakeThresh;
            cfg_reg.tick_ms             <= RstTickMs;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> sv/vpsc_seq.sv
// Power-state sequencer: clock, timers, state and one step per beat.
// Depends on vpsc_pkg for vstate_t, cfg_t, item_t and result_t.
module vpsc_seq
    import vpsc_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    step_en,
    input  cfg_t    cfg,
    input  item_t   item,
    output result_t result
);

    logic [31:0] now_reg,       now_next;
    vstate_t     state_reg,     state_next;
    logic        boot_run_reg,  boot_run_next;
    logic [31:0] boot_end_reg,  boot_end_next;
    logic [31:0] sleep_end_reg, sleep_end_next;
    logic        flag_reg,      flag_next;

    logic [31:0] now_adv;
    logic [31:0] hold_end;
    logic [31:0] delay_end;
    logic [31:0] boot_len;
    logic [31:0] timer_end;
    logic        brake_ok;
    logic        expired;
    logic        sleep_ext;

    // Shared adders: advanced clock, hold target, delay target, boot/fallback end
    assign now_adv   = now_reg + {24'd0, cfg.tick_ms};
    assign hold_end  = now_adv + {12'd0, cfg.sleep_hold_ms};
    assign delay_end = now_reg + {12'd0, item.delay_ms};
    assign boot_len  = cfg.leader_mode ? {16'd0, cfg.boot_delay_ms}
                                       : {16'd0, cfg.follower_timeout_ms};
    assign timer_end = now_adv + boot_len;
    assign brake_ok  = item.brake_valid && (item.brake_tenths > cfg.brake_threshold);

    always_comb begin
        now_next       = now_reg;
        state_next     = state_reg;
        boot_run_next  = boot_run_reg;
        boot_end_next  = boot_end_reg;
        sleep_end_next = sleep_end_reg;
        flag_next      = flag_reg;
        sleep_ext      = 1'b0;
        expired        = 1'b0;

        if (item.opcode == OP_DELAY) begin
            // Delay beat: only the hold may move later
            if (sleep_end_reg < delay_end) begin
                sleep_end_next = delay_end;
            end
        end else begin
            now_next = now_adv;
            if (cfg.leader_mode) begin
                // Leader transitions
                unique case (state_reg)
                    S_INIT: begin
                        if (boot_run_reg && (now_adv >= boot_end_reg)) begin
                            state_next    = S_ON_GLV;
                            boot_run_next = 1'b0;
                        end
                    end
                    S_ON_GLV: begin
                        if (item.tsms_active) state_next = S_ON_HV;
                    end
                    S_ON_HV: begin
                        if (!item.tsms_active) begin
                            state_next = S_ON_GLV;
                        end else if (item.contactors_closed && item.run_button
                                     && brake_ok) begin
                            state_next = S_TS_RUN;
                        end
                    end
                    S_TS_RUN: begin
                        if (!item.tsms_active) state_next = S_ON_GLV;
                    end
                    S_SLEEP: begin
                        state_next = S_SLEEP;
                    end
                    default: begin
                        state_next = state_reg;
                    end
                endcase
                // High voltage keeps pushing the hold out
                sleep_ext = (state_next == S_ON_HV) || (state_next == S_TS_RUN);
                if (sleep_ext && (sleep_end_reg < hold_end)) begin
                    sleep_end_next = hold_end;
                end
            end else begin
                // Follower: copy the received state, fall back on timeout
                if (item.remote_valid) begin
                    boot_run_next = 1'b0;
                    if (item.remote_state <= CODE_SLEEP) begin
                        state_next = code_to_state(item.remote_state);
                    end
                end else if (!boot_run_reg) begin
                    boot_run_next = 1'b1;
                    boot_end_next = timer_end;
                end else if (now_adv >= boot_end_reg) begin
                    state_next    = S_ON_GLV;
                    boot_run_next = 1'b0;
                end
            end

            // Hold expiry, sleep entry and wake-up re-init
            expired   = now_adv >= sleep_end_next;
            flag_next = expired;
            if (cfg.leader_mode) begin
                if (expired) begin
                    if (item.followers_sleep_ok && !item.uds_active) begin
                        state_next = S_SLEEP;
                    end
                end else if (state_next == S_SLEEP) begin
                    state_next     = S_INIT;
                    flag_next      = 1'b0;
                    sleep_end_next = hold_end;
                    boot_run_next  = 1'b1;
                    boot_end_next  = timer_end;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            now_reg       <= '0;
            state_reg     <= S_INIT;
            boot_run_reg  <= RstLeaderMode;
            boot_end_reg  <= {16'd0, RstBootTimeMs};
            sleep_end_reg <= {12'd0, RstSleepHoldMs};
            flag_reg      <= 1'b0;
        end else if (step_en) begin
            now_reg       <= now_next;
            state_reg     <= state_next;
            boot_run_reg  <= boot_run_next;
            boot_end_reg  <= boot_end_next;
            sleep_end_reg <= sleep_end_next;
            flag_reg      <= flag_next;
        end
    end

    assign result.current_state = state_to_code(state_next);
    assign result.sleepable     = flag_next;

endmodule

>>> sv/vehicle_power_state_controller.sv
// Top level of the vehicle power-state controller: stream ports, input and
// result registers. Depends on vpsc_pkg, vpsc_cfg and vpsc_seq.
//
//  Channel  | Dir | Beat fields
//  ---------+-----+-----------------------------------------------------------
//  s_       | in  | tuser: opcode; tdata: delay, switches, brake, remote state
//  m_       | out | tdata: current_state, sleepable
//  cfg_     | in  | cfg_index: register index, cfg_data: register value
//
// One beat per cycle sustained while the result stream is not stalled; a beat passes
// through the input register, then the sequencer step into the result register.
// The sequencer state updates in the same cycle the result is registered.
// Reset is synchronous; no clearing pass.
// A stalled result register holds the input stage, which then deasserts s_tready.
module vehicle_power_state_controller
    import vpsc_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    // input stream
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [39:0]         s_tdata,   // delay_ms[19:0], tsms_active, run_button,
                                           // contactors_closed, brake_valid,
                                           // brake_tenths[9:0], followers_sleep_ok,
                                           // uds_active, remote_valid, remote_state[2:0]
    input  logic                s_tuser,   // opcode
    // result stream
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [7:0]          m_tdata,   // current_state[2:0], sleepable, zero pad
    // configuration writes
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [CfgIdxW-1:0]  cfg_index,
    input  logic [CfgDataW-1:0] cfg_data
);

    cfg_t    cfg;
    item_t   in_item;
    item_t   item_reg;
    logic    in_valid_reg;
    result_t step_res;
    result_t res_reg;
    logic    out_valid_reg;
    logic    advance;
    logic    in_take;

    assign cfg_ready = 1'b1;

    vpsc_cfg u_cfg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    // Unpack an input beat
    always_comb begin
        in_item.opcode             = s_tuser;
        in_item.delay_ms           = s_tdata[19:0];
        in_item.tsms_active        = s_tdata[20];
        in_item.run_button         = s_tdata[21];
        in_item.contactors_closed  = s_tdata[22];
        in_item.brake_valid        = s_tdata[23];
        in_item.brake_tenths       = s_tdata[33:24];
        in_item.followers_sleep_ok = s_tdata[34];
        in_item.uds_active         = s_tdata[35];
        in_item.remote_valid       = s_tdata[36];
        in_item.remote_state       = s_tdata[39:37];
    end

    // Pipeline flow: step when the result register is free or draining
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign in_take  = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_take) begin
            item_reg <= in_item;
        end
    end

    vpsc_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (advance),
        .cfg     (cfg),
        .item    (item_reg),
        .result  (step_res)
    );

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            res_reg <= step_res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'd0, res_reg.sleepable, res_reg.current_state};

endmodule
